### design/assert_macros.svh
// Assertion helpers for the page replacement unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

### design/aprep_pkg.sv
`default_nettype none
package aprep_pkg;
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DONE
   } state_type;

   localparam int unsigned NUM_PAGES = 1024;
   localparam int unsigned NUM_FRAMES = 16;
   localparam int unsigned COUNT_WIDTH = 32;
   localparam int unsigned PAGE_WIDTH = 10;
   localparam int unsigned FRAME_WIDTH = 4;
   localparam int unsigned CFG_WIDTH = 5;
endpackage
`default_nettype wire

### design/aprep_ram.sv
`default_nettype none
module aprep_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### design/aging_page_replacement_unit.sv
// Aging page replacement unit.
// A request carries one page number on req_page_number; it is taken at a clock
// edge where req_valid is high and req_stall is low. Each request yields exactly
// one response on the rsp_ ports, held while rsp_valid is high and rsp_stall is
// high.
// Instead of shifting every page's age on each reference, the unit keeps a
// reference counter and stores, per page, the stamp of its last reference and
// its age at that time in one memory word. Each frame keeps a copy of its page's
// stamp and age so that the minimum search runs over the frames in parallel.
// The memory word is read at the edge that takes the request; in the next cycle
// hit, empty frame and victim are resolved and the response is loaded, so it is
// valid once the unit has moved from ST_READ into ST_DONE. The input stays stalled
// until the response is taken, through ST_READ, ST_DONE and any receiver stalls.
// csr_write_enable writes frames_in_use (reset 16); it is only to be written
// while no request is in flight.
// Synchronous reset clears the frame valid flags and the counters and starts a
// clearing pass over all 1024 words of the age memory, during which req_stall
// is high.
`default_nettype none
`include "assert_macros.svh"
module aging_page_replacement_unit #(
   parameter int unsigned AGE_WIDTH  = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [aprep_pkg::CFG_WIDTH-1:0]    csr_write_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [aprep_pkg::PAGE_WIDTH-1:0]   req_page_number,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_hit,
   output logic [aprep_pkg::FRAME_WIDTH-1:0]       rsp_frame_index,
   output logic                                    rsp_evicted_valid,
   output logic [aprep_pkg::PAGE_WIDTH-1:0]        rsp_evicted_page,
   output logic [aprep_pkg::COUNT_WIDTH-1:0]       rsp_hit_total,
   output logic [aprep_pkg::COUNT_WIDTH-1:0]       rsp_miss_total
);
   import aprep_pkg::*;

   localparam int unsigned PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   // A page's age is kept as its age at its last reference together with the
   // stamp of that reference; the current age is that value shifted right by
   // the references since. A gap of AGE_WIDTH references or more gives zero.
   localparam int unsigned SW = 32;
   localparam int unsigned MW = AGE_WIDTH + SW;

   state_type state_ff, state_in;
   logic [CFG_WIDTH-1:0] cfg_ff;
   logic [SW-1:0] now_ff;
   logic [PW-1:0] page_ff;
   logic [PW-1:0] clear_addr_ff;
   logic [PAGE_WIDTH-1:0] fpage_ff [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] fvalid_ff;
   logic [AGE_WIDTH-1:0] fhist_ff [NUM_FRAMES];
   logic [SW-1:0] fstamp_ff [NUM_FRAMES];
   logic [COUNT_WIDTH-1:0] hits_ff, misses_ff;

   logic [MW-1:0] mem_rd, mem_wr;
   logic [PW-1:0] mem_addr;
   logic mem_we;

   aprep_ram #(.WIDTH(MW), .DEPTH(NUM_PAGES)) u_age_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_addr),
      .wr_data(mem_wr),
      .rd_addr(req_page_number[PW-1:0]),
      .rd_data(mem_rd)
   );

   function automatic logic [AGE_WIDTH-1:0] age_at(
      input logic [AGE_WIDTH-1:0] h, input logic [SW-1:0] st,
      input logic [SW-1:0] now);
      logic [SW-1:0] d;
      d = now - st;
      if (d >= SW'(AGE_WIDTH)) begin
         return '0;
      end
      return h >> d;
   endfunction

   logic [FW:0] n_mgr;
   always_comb begin
      n_mgr = (cfg_ff == '0) ? (FW+1)'(1) : (FW+1)'(cfg_ff);
      if (32'(cfg_ff) > NUM_FRAMES) begin
         n_mgr = (FW+1)'(NUM_FRAMES);
      end
   end

   // Page history after this reference.
   logic [AGE_WIDTH-1:0] old_hist, new_hist;
   logic [SW-1:0] now_next;
   assign now_next = now_ff + 1'b1;
   always_comb begin
      old_hist = age_at(mem_rd[AGE_WIDTH-1:0], mem_rd[MW-1:AGE_WIDTH], now_next);
      new_hist = old_hist | {1'b1, {(AGE_WIDTH-1){1'b0}}};
   end

   logic hit_c, empty_c;
   logic [FW-1:0] hit_f, empty_f, vict_f;
   always_comb begin
      hit_c = 1'b0; empty_c = 1'b0;
      hit_f = '0; empty_f = '0;
      for (int i = NUM_FRAMES-1; i >= 0; i--) begin
         if ((FW+1)'(i) < n_mgr) begin
            if (fvalid_ff[i] && fpage_ff[i] == PAGE_WIDTH'(page_ff)) begin
               hit_c = 1'b1; hit_f = FW'(i);
            end
            if (!fvalid_ff[i]) begin
               empty_c = 1'b1; empty_f = FW'(i);
            end
         end
      end
   end

   // The smallest age is found by a tree of pairwise compares; on a tie the
   // lower frame wins.
   logic [AGE_WIDTH-1:0] tage [2*NUM_FRAMES];
   logic [FW-1:0] tidx [2*NUM_FRAMES];
   logic [2*NUM_FRAMES-1:0] tok;
   always_comb begin
      tage[0] = '0; tidx[0] = '0; tok[0] = 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         tage[NUM_FRAMES+i] = age_at(fhist_ff[i], fstamp_ff[i], now_next);
         tidx[NUM_FRAMES+i] = FW'(i);
         tok[NUM_FRAMES+i] = ((FW+1)'(i) < n_mgr);
      end
      for (int k = NUM_FRAMES-1; k >= 1; k--) begin
         if (tok[2*k+1] && (!tok[2*k] || tage[2*k+1] < tage[2*k])) begin
            tage[k] = tage[2*k+1]; tidx[k] = tidx[2*k+1];
         end else begin
            tage[k] = tage[2*k]; tidx[k] = tidx[2*k];
         end
         tok[k] = tok[2*k] | tok[2*k+1];
      end
      vict_f = tidx[1];
   end

   logic [FW-1:0] sel_f;
   assign sel_f = hit_c ? hit_f : (empty_c ? empty_f : vict_f);
   assign mem_we = (state_ff == ST_CLEAR) || (state_ff == ST_READ);
   assign mem_addr = (state_ff == ST_CLEAR) ? clear_addr_ff : page_ff;
   assign mem_wr = (state_ff == ST_CLEAR) ? '0 : {now_next, new_hist};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clear_addr_ff == PW'(NUM_PAGES - 1)) state_in = ST_IDLE;
         ST_IDLE: if (req_valid) state_in = ST_READ;
         ST_READ: state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_addr_ff <= '0;
         cfg_ff <= CFG_WIDTH'(16);
         now_ff <= '0;
         fvalid_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clear_addr_ff <= clear_addr_ff + 1'b1;
         if (csr_write_enable) cfg_ff <= csr_write_data;
         if (state_ff == ST_IDLE && req_valid) page_ff <= req_page_number[PW-1:0];
         if (state_ff == ST_READ) begin
            now_ff <= now_next;
            rsp_hit <= hit_c;
            rsp_frame_index <= FRAME_WIDTH'(sel_f);
            rsp_evicted_valid <= !hit_c && !empty_c;
            rsp_evicted_page <= (!hit_c && !empty_c) ? fpage_ff[vict_f] : '0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
               if (fvalid_ff[i] && fpage_ff[i] == PAGE_WIDTH'(page_ff)) begin
                  fhist_ff[i] <= new_hist; fstamp_ff[i] <= now_next;
               end
            end
            if (hit_c) begin
               if (hits_ff != CMAX) hits_ff <= hits_ff + 1'b1;
            end else begin
               if (misses_ff != CMAX) misses_ff <= misses_ff + 1'b1;
               fvalid_ff[sel_f] <= 1'b1;
               fpage_ff[sel_f] <= PAGE_WIDTH'(page_ff);
               fhist_ff[sel_f] <= new_hist;
               fstamp_ff[sel_f] <= now_next;
            end
         end
      end
   end

   assign rsp_hit_total = hits_ff;
   assign rsp_miss_total = misses_ff;

   `ASSERT_IMPLIES(a_rsp_only_done, clock, reset, rsp_valid, state_ff == ST_DONE)
   `ASSERT_NEXT(a_read_to_done, clock, reset, state_ff == ST_READ, rsp_valid)
   `ASSERT_IMPLIES(a_evict_full, clock, reset, rsp_valid && rsp_evicted_valid, !rsp_hit)
endmodule
`default_nettype wire
